// ===== sv/swm_pkg.sv =====
// Shared types for the sliding window minimum block: controller states, commands, status.
package swm_pkg;

  // Width of the window length register
  localparam int CfgWidth = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_POP,
    ST_APPEND,
    ST_OUTPUT
  } swm_state_t;

  typedef struct packed {
    logic load_sample;
    logic drop_front;
    logic pop_back;
    logic append;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic expire_hit;
    logic pop_hit;
    logic out_free;
  } swm_stat_t;

endpackage

// ===== sv/swm_ctrl.sv =====
// Sequencer for one sample: accept, expire front, pop back, append, deliver result.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swm_stat_t stat,
  output swm_cmd_t  cmd
);

  swm_state_t state_r;
  swm_state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the steps of one sample
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        cmd.drop_front = stat.expire_hit;
        state_nxt      = ST_POP;
      end
      ST_POP: begin
        if (stat.pop_hit) begin
          cmd.pop_back = 1'b1;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swm_dpath.sv =====
// Deque storage, pointers, window length register and result register.
module swm_dpath
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_cmd_t                       cmd,
  output swm_stat_t                      stat,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           cfg_wr,
  input  logic        [CfgWidth-1:0]     cfg_window_len,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_min
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int OW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] LastIdx = AW'(WINDOW_MAX - 1);
  localparam logic [PW-1:0] LastPos = PW'(2 * WINDOW_MAX - 1);
  localparam logic [PW:0]   PosMod  = (PW + 1)'(2 * WINDOW_MAX);
  localparam logic [OW-1:0] OccMax  = OW'(WINDOW_MAX);
  localparam logic [31:0]   LenMax  = 32'(WINDOW_MAX);

  // Candidate ring
  logic signed [SAMPLE_WIDTH-1:0] val_mem [WINDOW_MAX];
  logic        [PW-1:0]           pos_mem [WINDOW_MAX];

  logic        [AW-1:0]           head_r, head_nxt;
  logic        [AW-1:0]           tail_r, tail_nxt;
  logic        [OW-1:0]           occ_r, occ_nxt;
  logic        [PW-1:0]           pos_r;
  logic        [CfgWidth-1:0]     len_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           empty_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_min_r;

  logic signed [SAMPLE_WIDTH-1:0] head_val_q;
  logic        [PW-1:0]           head_pos_q;
  logic signed [SAMPLE_WIDTH-1:0] back_val_q;

  logic [AW-1:0] head_inc, tail_inc, tail_dec, rd_a_addr, rd_b_addr;
  logic [PW-1:0] pos_inc;
  logic [PW:0]   age;
  logic [31:0]   len_raw, len_eff;
  logic          ring_full;

  // Ring pointer arithmetic
  assign head_inc  = (head_r == LastIdx) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == LastIdx) ? '0 : tail_r + 1'b1;
  assign tail_dec  = (tail_r == '0) ? LastIdx : tail_r - 1'b1;
  assign pos_inc   = (pos_r == LastPos) ? '0 : pos_r + 1'b1;
  assign ring_full = (occ_r == OccMax);

  // Next pointers and fill level
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    if (cmd.drop_front || (cmd.append && ring_full)) begin
      head_nxt = head_inc;
    end
    if (cmd.pop_back) begin
      tail_nxt = tail_dec;
    end else if (cmd.append) begin
      tail_nxt = tail_inc;
    end
    if (cmd.pop_back || cmd.drop_front) begin
      occ_nxt = occ_r - 1'b1;
    end else if (cmd.append && !ring_full) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  // Read the front at the next head and the back just below the next tail
  assign rd_a_addr = head_nxt;
  assign rd_b_addr = (tail_nxt == '0) ? LastIdx : tail_nxt - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      val_mem[tail_r] <= sample_r;
      pos_mem[tail_r] <= pos_r;
    end
    head_val_q <= val_mem[rd_a_addr];
    head_pos_q <= pos_mem[rd_a_addr];
    back_val_q <= val_mem[rd_b_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      pos_r       <= '0;
      len_r       <= CfgWidth'(1);
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      if (cmd.append) begin
        pos_r <= pos_inc;
      end
      if (cfg_wr) begin
        len_r <= cfg_window_len;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_r <= in_sample;
    end
    if (cmd.append) begin
      empty_r <= (occ_r == '0);
    end
    if (cmd.load_out) begin
      out_min_r <= empty_r ? sample_r : head_val_q;
    end
  end

  // Clamp the window length to 1..WINDOW_MAX
  assign len_raw = 32'(len_r);
  always_comb begin
    if (len_raw == 32'd0) begin
      len_eff = 32'd1;
    end else if (len_raw > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = len_raw;
    end
  end

  // Age of the front entry, modulo twice the ring size
  assign age = (pos_r >= head_pos_q) ? {1'b0, pos_r} - {1'b0, head_pos_q}
                                     : {1'b0, pos_r} + PosMod - {1'b0, head_pos_q};

  assign stat.expire_hit = (occ_r != '0) && (32'(age) >= len_eff);
  assign stat.pop_hit    = (occ_r != '0) && (back_val_q > sample_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;

endmodule

// ===== sv/sliding_window_minimum_core.sv =====
// Sliding window minimum: one result per sample via accept, expire, pop, append, output.
// The result loads once the output slot is free; only then is a new sample accepted.
// The pop step retires one back entry per cycle through the ring's second read port.
// Reset (rst_n low, synchronous) empties the deque, clears positions and sets window_len 1;
// the candidate ring itself is not cleared, entries are used only once written.
module sliding_window_minimum_core
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_min,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [CfgWidth-1:0]     cfg_window_len
);

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swm_dpath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample      (in_sample),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_window_len (cfg_window_len),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_window_min (out_window_min)
  );

  // One sample in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input beat accepted while a sample is in flight");

  // Result loads only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an undelivered beat");

  // Sequencer steps never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_sample, cmd.pop_back, cmd.append, cmd.load_out}))
    else $error("overlapping sequencer commands");

endmodule
